// ===== rtl/core/lge_pkg.sv =====
package lge_pkg;

    // Field widths of the stream words and the register port
    localparam int ACT_W      = 2;
    localparam int IDX_W      = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 8;
    localparam int M_USER_W   = 1;

    // Default grid bounds
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // B3/S23 neighbor counts
    localparam int NBR_W = 4;
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_READ  = 2'd2
    } lge_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } lge_reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_STEP,
        ST_RESULT
    } lge_state_t;

    typedef struct packed {
        logic cell_alive;
        logic bad_address;
    } lge_res_t;

endpackage

// ===== rtl/core/life_generation_engine.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: row, col, value; s_tuser: action
// m_        out  m_tvalid/m_tready  m_tdata: cell_alive; m_tuser: bad_address
// cfg_      in   cfg_wen            cfg_index, cfg_wdata (grid_rows, grid_cols)
//
// Cell write or read: the row read is issued on acceptance, ST_CELL updates or reads the
// cell, then ST_RESULT; a bad address or unknown action goes straight to ST_RESULT. Step:
// one grid row per cycle through the single row-wide plane memory read port, whole row
// computed in parallel. Reset is synchronous; afterwards plane zero is cleared one row
// per cycle with s_tready low. Configuration writes are taken at any time.
// A result word waits in the output register while the next word is accepted.
module life_generation_engine #(
    parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lge_pkg::S_DATA_W-1:0]      s_tdata,   // row_index, col_index, cell_value, pad
    input  logic [lge_pkg::ACT_W-1:0]         s_tuser,   // action
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lge_pkg::M_DATA_W-1:0]      m_tdata,   // cell_alive, pad
    output logic [lge_pkg::M_USER_W-1:0]      m_tuser,   // bad_address
    // register writes
    input  logic                              cfg_wen,
    input  logic [lge_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lge_pkg::CFG_W-1:0]         cfg_wdata
);

    import lge_pkg::*;

    localparam int RCNT_W = $clog2(MAX_ROWS+1);
    localparam int CCNT_W = $clog2(MAX_COLS+1);
    localparam int RS_W   = (RCNT_W > CFG_W) ? RCNT_W : CFG_W;
    localparam int CS_W   = (CCNT_W > CFG_W) ? CCNT_W : CFG_W;

    logic [RCNT_W-1:0] rows_used_reg, rows_used_next;
    logic [CCNT_W-1:0] cols_used_reg, cols_used_next;
    logic [RS_W-1:0]   wr_rows;
    logic [CS_W-1:0]   wr_cols;
    logic [RCNT_W-1:0] rows_sat;
    logic [CCNT_W-1:0] cols_sat;

    logic              m_tvalid_reg, m_tvalid_next;
    lge_res_t          m_res_reg, m_res_next;

    logic              res_valid;
    logic              res_ready;
    lge_res_t          res;

    // Saturate a written size to 1..max
    assign wr_rows  = RS_W'(cfg_wdata);
    assign wr_cols  = CS_W'(cfg_wdata);
    assign rows_sat = (wr_rows == '0) ? RCNT_W'(1)
                    : (wr_rows > RS_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : RCNT_W'(wr_rows);
    assign cols_sat = (wr_cols == '0) ? CCNT_W'(1)
                    : (wr_cols > CS_W'(MAX_COLS)) ? CCNT_W'(MAX_COLS) : CCNT_W'(wr_cols);

    // Register write decode
    always_comb begin
        rows_used_next = rows_used_reg;
        cols_used_next = cols_used_reg;
        if (cfg_wen) begin
            unique case (cfg_index)
                REG_GRID_ROWS: rows_used_next = rows_sat;
                REG_GRID_COLS: cols_used_next = cols_sat;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_used_reg <= RCNT_W'(MAX_ROWS);
            cols_used_reg <= CCNT_W'(MAX_COLS);
        end else begin
            rows_used_reg <= rows_used_next;
            cols_used_reg <= cols_used_next;
        end
    end

    lge_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (lge_action_t'(s_tuser)),
        .row_idx   (s_tdata[IDX_W-1:0]),
        .col_idx   (s_tdata[2*IDX_W-1:IDX_W]),
        .cell_val  (s_tdata[2*IDX_W]),
        .rows_used (rows_used_reg),
        .cols_used (cols_used_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: load a finished result when the slot is free or draining
    assign res_ready = ~m_tvalid_reg | m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(m_res_reg.cell_alive);
    assign m_tuser  = M_USER_W'(m_res_reg.bad_address);

endmodule

// ===== rtl/core/lge_plane_mem.sv =====
module lge_plane_mem #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    // One row per entry; write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/lge_row_rule.sv =====
module lge_row_rule #(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0] row_up,
    input  logic [COLS-1:0] row_mid,
    input  logic [COLS-1:0] row_dn,
    input  logic [COLS-1:0] col_mask,
    output logic [COLS-1:0] row_next
);

    import lge_pkg::*;

    logic [COLS+1:0] up_p;
    logic [COLS+1:0] mid_p;
    logic [COLS+1:0] dn_p;

    // Pad both ends with dead cells so edge columns see no wrap
    assign up_p  = {1'b0, row_up,  1'b0};
    assign mid_p = {1'b0, row_mid, 1'b0};
    assign dn_p  = {1'b0, row_dn,  1'b0};

    // Count the eight neighbors of each column and apply B3/S23
    always_comb begin
        logic [NBR_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < COLS; i++) begin
            cnt = NBR_W'(up_p[i]) + NBR_W'(up_p[i+1]) + NBR_W'(up_p[i+2])
                + NBR_W'(mid_p[i]) + NBR_W'(mid_p[i+2])
                + NBR_W'(dn_p[i]) + NBR_W'(dn_p[i+1]) + NBR_W'(dn_p[i+2]);
            row_next[i] = col_mask[i]
                & ((cnt == BIRTH_COUNT) | (row_mid[i] & (cnt == SURVIVE_COUNT)));
        end
    end

endmodule

// ===== rtl/core/lge_seq.sv =====
module lge_seq #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // item side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  lge_pkg::lge_action_t              action,
    input  logic [lge_pkg::IDX_W-1:0]         row_idx,
    input  logic [lge_pkg::IDX_W-1:0]         col_idx,
    input  logic                              cell_val,
    // grid size in use
    input  logic [$clog2(MAX_ROWS+1)-1:0]     rows_used,
    input  logic [$clog2(MAX_COLS+1)-1:0]     cols_used,
    // result side
    output logic                              res_valid,
    input  logic                              res_ready,
    output lge_pkg::lge_res_t                 res
);

    import lge_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int RCNT_W = $clog2(MAX_ROWS+1);
    localparam int CCNT_W = $clog2(MAX_COLS+1);
    localparam int SW_W   = $clog2(MAX_ROWS+2);
    localparam int RC_W   = (RCNT_W > IDX_W) ? RCNT_W : IDX_W;
    localparam int CC_W   = (CCNT_W > IDX_W) ? CCNT_W : IDX_W;
    localparam int ADDR_W = ROW_W + 1;

    localparam logic [SW_W-1:0] CLEAR_LAST = SW_W'(MAX_ROWS - 1);
    localparam logic [SW_W-1:0] READ_END   = SW_W'(MAX_ROWS);
    localparam logic [SW_W-1:0] STEP_LAST  = SW_W'(MAX_ROWS + 1);

    lge_state_t          state_reg, state_next;
    logic [SW_W-1:0]     cnt_reg, cnt_next;
    logic                cur_reg, cur_next;
    lge_action_t         act_reg, act_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic                val_reg, val_next;
    logic [MAX_COLS-1:0] up_reg, up_next;
    logic [MAX_COLS-1:0] mid_reg, mid_next;
    lge_res_t            res_reg, res_next;

    logic                accept;
    logic [RC_W-1:0]     row_ext;
    logic [CC_W-1:0]     col_ext;
    logic                addr_bad;
    logic                cell_act;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] in_row;
    logic [MAX_COLS-1:0] rule_row;
    logic [SW_W-1:0]     out_row;
    logic                out_row_ok;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [MAX_COLS-1:0] rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    // Decode the incoming word
    assign accept   = s_tvalid & s_tready;
    assign row_ext  = RC_W'(row_idx);
    assign col_ext  = CC_W'(col_idx);
    assign addr_bad = (row_ext >= RC_W'(rows_used)) | (col_ext >= CC_W'(cols_used));
    assign cell_act = (action == ACT_WRITE) || (action == ACT_READ);

    // Columns inside the grid
    always_comb begin
        for (int i = 0; i < MAX_COLS; i++) begin
            col_mask[i] = (CCNT_W'(i) < cols_used);
        end
    end

    // Sweep window: row arriving from memory, masked to the grid
    assign in_row = ((cnt_reg != '0) && (cnt_reg <= SW_W'(rows_used)))
                  ? (rd_data & col_mask) : '0;
    assign out_row    = SW_W'(cnt_reg - SW_W'(2));
    assign out_row_ok = out_row < SW_W'(rows_used);

    lge_row_rule #(
        .COLS (MAX_COLS)
    ) u_rule (
        .row_up   (up_reg),
        .row_mid  (mid_reg),
        .row_dn   (in_row),
        .col_mask (col_mask),
        .row_next (rule_row)
    );

    lge_plane_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (MAX_COLS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (cnt_reg == CLEAR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (action) inside
                        ACT_WRITE, ACT_READ: state_next = addr_bad ? ST_RESULT : ST_CELL;
                        ACT_STEP:            state_next = ST_STEP;
                        default:             state_next = ST_RESULT;
                    endcase
                end
            end
            ST_CELL: begin
                state_next = ST_RESULT;
            end
            ST_STEP: begin
                if (cnt_reg == STEP_LAST) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory port controls
    always_comb begin
        s_tready  = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = {cur_reg, cnt_reg[ROW_W-1:0]};
        wr_en     = 1'b0;
        wr_addr   = {~cur_reg, out_row[ROW_W-1:0]};
        wr_data   = out_row_ok ? rule_row : '0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = {1'b0, cnt_reg[ROW_W-1:0]};
                wr_data = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                rd_en    = s_tvalid & cell_act & ~addr_bad;
                rd_addr  = {cur_reg, row_ext[ROW_W-1:0]};
            end
            ST_CELL: begin
                wr_en            = (act_reg == ACT_WRITE);
                wr_addr          = {cur_reg, row_reg};
                wr_data          = rd_data;
                wr_data[col_reg] = val_reg;
            end
            ST_STEP: begin
                rd_en = (cnt_reg < READ_END);
                wr_en = (cnt_reg >= SW_W'(2));
            end
            ST_RESULT: begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // Item fields, sweep counter, window and result
    always_comb begin
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        act_next = act_reg;
        row_next = row_reg;
        col_next = col_reg;
        val_next = val_reg;
        up_next  = up_reg;
        mid_next = mid_reg;
        res_next = res_reg;
        case (state_reg)
            ST_CLEAR: begin
                cnt_next = cnt_reg + SW_W'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    cnt_next             = '0;
                    act_next             = action;
                    row_next             = row_ext[ROW_W-1:0];
                    col_next             = col_ext[COL_W-1:0];
                    val_next             = cell_val;
                    up_next              = '0;
                    mid_next             = '0;
                    res_next.cell_alive  = 1'b0;
                    res_next.bad_address = cell_act & addr_bad;
                end
            end
            ST_CELL: begin
                res_next.cell_alive  = (act_reg == ACT_READ) & rd_data[col_reg];
                res_next.bad_address = 1'b0;
            end
            ST_STEP: begin
                cnt_next = cnt_reg + SW_W'(1);
                if (cnt_reg != '0) begin
                    up_next  = mid_reg;
                    mid_next = in_row;
                end
                if (cnt_reg == STEP_LAST) begin
                    cur_next = ~cur_reg;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            cur_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        act_reg <= act_next;
        row_reg <= row_next;
        col_reg <= col_next;
        val_reg <= val_next;
        up_reg  <= up_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

    // A sweep never writes the plane it reads
    a_plane_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && rd_en && wr_en)
            |-> (rd_addr[ADDR_W-1] != wr_addr[ADDR_W-1]))
        else $error("step reads and writes the same plane");

    // The finished sweep swaps the planes
    a_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && cnt_reg == STEP_LAST) |=> (cur_reg != $past(cur_reg)))
        else $error("planes not swapped after step");

    // Sweep counter stays within the grid plus the drain cycles
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (cnt_reg <= STEP_LAST))
        else $error("step counter overran");

    // Cell update always follows a read issued on acceptance
    a_cell_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CELL) |-> ($past(state_reg) == ST_IDLE && $past(rd_en)))
        else $error("cell update without row read");

endmodule
